@@ rtl/id3p_pkg.sv @@
`timescale 1ns / 1ps

package id3p_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } id3p_in_t;

  typedef struct packed {
    logic [1:0] result_type;
    logic [1:0] frame_kind;
    logic [7:0] text_byte;
    logic       last_of_frame;
    logic       last_of_run;
  } id3p_out_t;

  // result_type codes
  localparam logic [1:0] RES_TEXT     = 2'd0;
  localparam logic [1:0] RES_TAG_END  = 2'd1;
  localparam logic [1:0] RES_BAD_SIZE = 2'd2;
  localparam logic [1:0] RES_NO_SIG   = 2'd3;

  // frame kinds; KIND_NONE marks a frame whose payload is skipped
  localparam logic [1:0] KIND_TITLE  = 2'd0;
  localparam logic [1:0] KIND_ARTIST = 2'd1;
  localparam logic [1:0] KIND_ALBUM  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;

  localparam int unsigned HeaderLen = 10;
  localparam int unsigned TagLenW   = 28;
  localparam logic [6:0]  SyncMask  = 7'h7F;

  typedef enum logic [4:0] {
    PH_WAIT     = 5'b00001,
    PH_TAGHDR   = 5'b00010,
    PH_FRAMEHDR = 5'b00100,
    PH_PAYLOAD  = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_e;

  // "ID3" signature, one byte per header position
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h49;
      2'd1:    b = 8'h44;
      2'd2:    b = 8'h33;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] kind_of(input logic [31:0] id);
    logic [1:0] k;
    priority if (id == ID_TIT2) k = KIND_TITLE;
    else if (id == ID_TPE1)     k = KIND_ARTIST;
    else if (id == ID_TALB)     k = KIND_ALBUM;
    else                        k = KIND_NONE;
    return k;
  endfunction

endpackage

@@ rtl/id3p_core.sv @@
`timescale 1ns / 1ps

// Byte-wise parse state. On each accepted byte it updates the state and
// produces zero, one or two results.
module id3p_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  id3p_pkg::id3p_in_t  in_i,
  output logic [1:0]          res_cnt_o,
  output id3p_pkg::id3p_out_t res0_o,
  output id3p_pkg::id3p_out_t res1_o
);

  localparam int unsigned TW = id3p_pkg::TagLenW;
  localparam logic [TW-1:0] HLen = TW'(id3p_pkg::HeaderLen);

  id3p_pkg::phase_e phase_q, phase_d, phase_eff;
  logic [3:0]    cnt_q, cnt_d, cnt_eff;
  logic [TW-1:0] tag_len_q, tag_len_d;
  logic [TW-1:0] tag_pos_q, tag_pos_d;
  logic [TW-1:0] room_q, room_d;
  logic [TW-1:0] next_pos_q, next_pos_d;
  logic [TW-1:0] left_q, left_d, left_dec;
  logic [31:0]   fourcc_q, fourcc_d;
  logic [31:0]   frame_len_q, frame_len_d;
  logic [1:0]    kind_q, kind_d;
  logic [TW-1:0] tag_len_new;
  logic [TW:0]   next_end;
  logic [7:0]    b;

  function automatic id3p_pkg::id3p_out_t mk_res(input logic [1:0] t,
                                                input logic [1:0] k,
                                                input logic [7:0] d,
                                                input logic       lof);
    id3p_pkg::id3p_out_t r;
    r.result_type   = t;
    r.frame_kind    = k;
    r.text_byte     = d;
    r.last_of_frame = lof;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  assign b         = in_i.data_byte;
  assign phase_eff = in_i.start_of_file ? id3p_pkg::PH_TAGHDR : phase_q;
  assign cnt_eff   = in_i.start_of_file ? 4'd0 : cnt_q;

  assign tag_len_new = (cnt_eff >= 4'd6)
                     ? {tag_len_q[TW-8:0], b[6:0] & id3p_pkg::SyncMask} : tag_len_q;
  assign left_dec    = left_q - TW'(1);
  assign next_end    = {1'b0, next_pos_q} + {1'b0, HLen};

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    tag_len_d   = tag_len_q;
    tag_pos_d   = tag_pos_q;
    room_d      = room_q;
    next_pos_d  = next_pos_q;
    left_d      = left_q;
    fourcc_d    = fourcc_q;
    frame_len_d = frame_len_q;
    kind_d      = kind_q;
    res_cnt_o   = 2'd0;
    res0_o      = '0;
    res1_o      = '0;

    if (accept_i) begin
      phase_d = phase_eff;
      cnt_d   = cnt_eff;
      unique case (phase_eff)
        id3p_pkg::PH_TAGHDR: begin
          if (cnt_eff < 4'd3 && b != id3p_pkg::sig_byte(cnt_eff[1:0])) begin
            res0_o    = mk_res(id3p_pkg::RES_NO_SIG, 2'd0, 8'd0, 1'b0);
            res_cnt_o = 2'd1;
            phase_d   = id3p_pkg::PH_DONE;
          end else begin
            tag_len_d = tag_len_new;
            cnt_d     = 4'(cnt_eff + 4'd1);
            if (cnt_eff >= 4'd9) begin
              cnt_d     = 4'd0;
              tag_pos_d = '0;
              if (tag_len_new > HLen) begin
                phase_d = id3p_pkg::PH_FRAMEHDR;
              end else begin
                res0_o    = mk_res(id3p_pkg::RES_TAG_END, 2'd0, 8'd0, 1'b0);
                res_cnt_o = 2'd1;
                phase_d   = id3p_pkg::PH_DONE;
              end
            end
          end
        end
        id3p_pkg::PH_FRAMEHDR: begin
          if (cnt_eff < 4'd4) begin
            fourcc_d = {fourcc_q[23:0], b};
          end else if (cnt_eff < 4'd8) begin
            frame_len_d = {frame_len_q[23:0], b};
          end
          cnt_d = 4'(cnt_eff + 4'd1);
          if (cnt_eff >= 4'd9) begin
            cnt_d = 4'd0;
            if (frame_len_q == 32'd0 || frame_len_q > {{(32-TW){1'b0}}, room_q}) begin
              res0_o    = mk_res(id3p_pkg::RES_BAD_SIZE, 2'd0, 8'd0, 1'b0);
              res_cnt_o = 2'd1;
              phase_d   = id3p_pkg::PH_DONE;
            end else begin
              kind_d     = id3p_pkg::kind_of(fourcc_q);
              left_d     = frame_len_q[TW-1:0];
              next_pos_d = tag_pos_q + HLen + frame_len_q[TW-1:0];
              phase_d    = id3p_pkg::PH_PAYLOAD;
            end
          end else begin
            // header bytes leave time to settle the space left in the tag
            room_d = tag_len_q - tag_pos_q - HLen;
          end
        end
        id3p_pkg::PH_PAYLOAD: begin
          left_d = left_dec;
          if (kind_q != id3p_pkg::KIND_NONE) begin
            res0_o    = mk_res(id3p_pkg::RES_TEXT, kind_q, b, left_dec == '0);
            res_cnt_o = 2'd1;
          end
          if (left_dec == '0) begin
            tag_pos_d = next_pos_q;
            kind_d    = 2'd0;
            if (next_end < {1'b0, tag_len_q}) begin
              phase_d = id3p_pkg::PH_FRAMEHDR;
            end else begin
              phase_d = id3p_pkg::PH_DONE;
              if (kind_q != id3p_pkg::KIND_NONE) begin
                res1_o    = mk_res(id3p_pkg::RES_TAG_END, 2'd0, 8'd0, 1'b0);
                res_cnt_o = 2'd2;
              end else begin
                res0_o    = mk_res(id3p_pkg::RES_TAG_END, 2'd0, 8'd0, 1'b0);
                res_cnt_o = 2'd1;
              end
            end
          end
        end
        default: ;
      endcase
      if (res_cnt_o == 2'd1) res0_o.last_of_run = 1'b1;
      if (res_cnt_o == 2'd2) res1_o.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= id3p_pkg::PH_WAIT;
      cnt_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_len_q   <= tag_len_d;
    tag_pos_q   <= tag_pos_d;
    room_q      <= room_d;
    next_pos_q  <= next_pos_d;
    left_q      <= left_d;
    fourcc_q    <= fourcc_d;
    frame_len_q <= frame_len_d;
    kind_q      <= kind_d;
  end

endmodule

@@ rtl/id3p_fifo.sv @@
`timescale 1ns / 1ps

// Result queue: takes up to two results per cycle, hands out one.
module id3p_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  id3p_pkg::id3p_out_t push0_i,
  input  id3p_pkg::id3p_out_t push1_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output id3p_pkg::id3p_out_t out_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastIdx = PW'(DEPTH - 1);

  id3p_pkg::id3p_out_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1, wr_ptr2;
  logic [CW-1:0] cnt_q;
  logic          pop;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == LastIdx) ? '0 : PW'(p + PW'(1));
  endfunction

  assign wr_ptr1     = inc(wr_ptr_q);
  assign wr_ptr2     = inc(wr_ptr1);
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room2_o     = cnt_q <= CW'(DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_cnt_i == 2'd1) wr_ptr_q <= wr_ptr1;
      if (push_cnt_i == 2'd2) wr_ptr_q <= wr_ptr2;
      if (pop) rd_ptr_q <= inc(rd_ptr_q);
      cnt_q <= CW'(cnt_q + CW'(push_cnt_i) - CW'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_ptr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_ptr1]  <= push1_i;
  end

endmodule

@@ rtl/id3v2_text_frame_parser_top.sv @@
`timescale 1ns / 1ps
// With an empty queue the first result of a byte is offered on out_valid_o in
// the cycle after the byte is accepted, a second one once the first is taken.
// Throughput: one byte per cycle while in_ready_o is high; a byte yields at most
// two results, and the result queue of FIFO_DEPTH entries drains one per cycle
// while out_ready_i is high, so in_ready_o drops only while fewer than two entries are free.
// Reset: rst_ni, asynchronous active low, empties the queue and waits for a
// byte flagged start_of_file before parsing.
module id3v2_text_frame_parser_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  id3p_pkg::id3p_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output id3p_pkg::id3p_out_t out_data_o
);

  logic                accept;
  logic [1:0]          res_cnt;
  id3p_pkg::id3p_out_t res0, res1;

  assign accept = in_valid_i && in_ready_o;

  id3p_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_i      (in_data_i),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  id3p_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .room2_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/id3p_checker.sv @@
`timescale 1ns / 1ps

module id3p_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input id3p_pkg::id3p_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input id3p_pkg::id3p_out_t out_data_o
);

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // status results always close the run of their byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_type != id3p_pkg::RES_TEXT
    |-> out_data_o.last_of_run && !out_data_o.last_of_frame)
    else $error("status result not last of run");

  // text bytes only come from recognized frames
  a_text_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_type == id3p_pkg::RES_TEXT
    |-> out_data_o.frame_kind != id3p_pkg::KIND_NONE)
    else $error("text byte with unrecognized kind");

  // a text byte that is not the frame end is the only result of its byte
  a_text_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_type == id3p_pkg::RES_TEXT
    && !out_data_o.last_of_frame |-> out_data_o.last_of_run)
    else $error("mid-frame text byte not last of run");

endmodule

bind id3v2_text_frame_parser_top id3p_props u_id3p_props (.*);
